@@ rtl/core/rrts_pkg.sv @@
// Package for the round-robin task scheduler.
// Holds defaults, code constants, request/result types and ctrl/datapath structs.
// No dependencies.
`default_nettype none

package rrts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TICK_BITS_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE  = 1'd1;

  localparam logic       ENABLE_RST = 1'b1;
  localparam logic [7:0] SLICE_RST  = 8'd10;

  // operation codes
  localparam logic [2:0] FUNC_TICK  = 3'd0;
  localparam logic [2:0] FUNC_YIELD = 3'd1;
  localparam logic [2:0] FUNC_SPAWN = 3'd2;
  localparam logic [2:0] FUNC_EXIT  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_IGNORED = 2'd2;

  // slot state codes
  localparam logic [1:0] SLOT_FREE  = 2'd0;
  localparam logic [1:0] SLOT_READY = 2'd1;
  localparam logic [1:0] SLOT_RUN   = 2'd2;

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] task_index;
  } req_t;

  typedef struct packed {
    logic        switched;
    logic [3:0]  previous_task;
    logic [3:0]  current_task;
    logic [1:0]  status;
    logic [3:0]  new_task;
    logic [4:0]  task_count;
    logic [1:0]  read_state;
    logic [31:0] read_ticks;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_RD,
    S_TICK_WR,
    S_PICK,
    S_SPAWN,
    S_READ_CAP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic set_ignored;
    logic tick_rd;
    logic tick_wr;
    logic pick_start;
    logic exit_free;
    logic pick_step;
    logic spawn_start;
    logic spawn_step;
    logic read_rd;
    logic read_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       enable;
    logic       run_is_zero;
    logic       expired;
    logic       search_done;
    logic       spawn_done;
    logic       out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/rrts_ctrl.sv @@
// Sequencer for the task scheduler: steps one request through its phases.
// Depends on rrts_pkg; drives rrts_dp through cmd_t, observes stat_t.
`default_nettype none

module rrts_ctrl
  import rrts_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat.func)
          FUNC_TICK:  state_next = stat.enable ? S_TICK_RD : S_FINISH;
          FUNC_YIELD: state_next = stat.enable ? S_PICK : S_FINISH;
          FUNC_SPAWN: state_next = S_SPAWN;
          FUNC_EXIT:  state_next = stat.run_is_zero ? S_FINISH : S_PICK;
          FUNC_READ:  state_next = S_READ_CAP;
          default:    state_next = S_FINISH;
        endcase
      end
      S_TICK_RD:  state_next = S_TICK_WR;
      S_TICK_WR:  state_next = stat.expired ? S_PICK : S_FINISH;
      S_PICK: begin
        if (stat.search_done) state_next = S_FINISH;
      end
      S_SPAWN: begin
        if (stat.spawn_done) state_next = S_FINISH;
      end
      S_READ_CAP: state_next = S_FINISH;
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_IDLE: cmd.load_item = in_valid;
      S_DECODE: begin
        unique case (stat.func)
          FUNC_TICK: begin
            if (!stat.enable) cmd.set_ignored = 1'b1;
          end
          FUNC_YIELD: begin
            if (stat.enable) cmd.pick_start  = 1'b1;
            else             cmd.set_ignored = 1'b1;
          end
          FUNC_SPAWN: cmd.spawn_start = 1'b1;
          FUNC_EXIT: begin
            if (stat.run_is_zero) begin
              cmd.set_ignored = 1'b1;
            end else begin
              cmd.exit_free  = 1'b1;
              cmd.pick_start = 1'b1;
            end
          end
          FUNC_READ: cmd.read_rd = 1'b1;
          default:   cmd.set_ignored = 1'b1;
        endcase
      end
      S_TICK_RD: cmd.tick_rd = 1'b1;
      S_TICK_WR: begin
        cmd.tick_wr    = 1'b1;
        cmd.pick_start = stat.expired;
      end
      S_PICK:     cmd.pick_step  = 1'b1;
      S_SPAWN:    cmd.spawn_step = 1'b1;
      S_READ_CAP: cmd.read_cap   = 1'b1;
      S_FINISH:   cmd.out_load   = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/rrts_dp.sv @@
// Datapath for the task scheduler: slot table, tick memory, search pointer,
// config registers and the result register. Depends on rrts_pkg.
`default_nettype none

module rrts_dp
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire req_t                  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rsp_t                       out_data,
  input  wire cmd_t                  cmd,
  output stat_t                      stat
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_TASKS - 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_TASKS - 2);
  localparam logic [IDX_W-1:0] FIRST_SPAWN = IDX_W'(1);

  // configuration
  logic       enable;
  logic [7:0] slice_len;

  // scheduler state; a used slot other than run is ready
  logic [MAX_TASKS-1:0] used;
  logic [MAX_TASKS-1:0] tick_vld;
  logic [IDX_W-1:0]     run;
  logic [7:0]           slice_cnt;
  logic [CNT_W-1:0]     count;

  // search unit
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] steps;

  // tick memory
  logic [TICK_BITS-1:0] mem [MAX_TASKS];
  logic [TICK_BITS-1:0] mem_rdata;
  logic                 mem_we;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]     mem_raddr;
  logic [TICK_BITS-1:0] mem_wdata;

  // per-request result
  logic [2:0]       func_r;
  logic [3:0]       idx_r;
  logic [IDX_W-1:0] prev_r;
  logic             sw_r;
  logic [1:0]       status_r;
  logic [IDX_W-1:0] newt_r;
  logic [1:0]       rstate_r;
  logic [31:0]      rticks_r;

  // combinational helpers
  logic [TICK_BITS-1:0]    ticks_cur;
  logic [TICK_BITS-1:0]    ticks_inc;
  logic [7:0]              slice_inc;
  logic                    expired;
  logic [IDX_W-1:0]        ptr_next;
  logic [IDX_W-1:0]        run_plus;
  logic                    pick_hit;
  logic                    pick_last;
  logic                    spawn_hit;
  logic                    spawn_last;
  logic                    exit_mode;
  logic [IDX_W+3:0]        idx_wide;
  logic [IDX_W-1:0]        rd_addr;
  logic                    rd_in_range;
  logic [TICK_BITS+31:0]   rticks_wide;
  logic [1:0]              rstate_val;
  logic [IDX_W+3:0]        prev_wide;
  logic [IDX_W+3:0]        run_wide;
  logic [IDX_W+3:0]        newt_wide;
  logic [CNT_W+4:0]        count_wide;
  logic                    out_free;

  always_comb begin
    ticks_cur   = tick_vld[run] ? mem_rdata : '0;
    ticks_inc   = ticks_cur + TICK_BITS'(1);
    slice_inc   = slice_cnt + 8'd1;
    expired     = (slice_inc >= slice_len);
    ptr_next    = (ptr == LAST_IDX) ? '0 : ptr + IDX_W'(1);
    run_plus    = (run == LAST_IDX) ? '0 : run + IDX_W'(1);
    pick_hit    = used[ptr];
    pick_last   = (steps == LAST_STEP);
    spawn_hit   = !used[ptr];
    spawn_last  = (ptr == LAST_IDX);
    exit_mode   = (func_r == FUNC_EXIT);
    idx_wide    = (IDX_W+4)'(idx_r);
    rd_addr     = idx_wide[IDX_W-1:0];
    rd_in_range = (idx_wide < (IDX_W+4)'(MAX_TASKS));
    rticks_wide = (TICK_BITS+32)'(mem_rdata);
    if (!used[rd_addr])      rstate_val = SLOT_FREE;
    else if (rd_addr == run) rstate_val = SLOT_RUN;
    else                     rstate_val = SLOT_READY;
    prev_wide   = (IDX_W+4)'(prev_r);
    run_wide    = (IDX_W+4)'(run);
    newt_wide   = (IDX_W+4)'(newt_r);
    count_wide  = (CNT_W+5)'(count);
    out_free    = !out_valid || !out_stall;
  end

  always_comb begin
    stat.func        = func_r;
    stat.enable      = enable;
    stat.run_is_zero = (run == '0);
    stat.expired     = expired;
    stat.search_done = pick_hit || pick_last;
    stat.spawn_done  = spawn_hit || spawn_last;
    stat.out_free    = out_free;
  end

  // one port each way; tick update and spawn clear never overlap
  always_comb begin
    mem_we    = cmd.tick_wr || (cmd.spawn_step && spawn_hit);
    mem_waddr = cmd.tick_wr ? run : ptr;
    mem_wdata = cmd.tick_wr ? ticks_inc : '0;
    mem_re    = cmd.tick_rd || cmd.read_rd;
    mem_raddr = cmd.tick_rd ? run : rd_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= ENABLE_RST;
      slice_len <= SLICE_RST;
      used      <= MAX_TASKS'(1);
      tick_vld  <= '0;
      run       <= '0;
      slice_cnt <= '0;
      count     <= CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == CFG_ENABLE) enable    <= cfg_data[0];
        if (cfg_index == CFG_SLICE)  slice_len <= cfg_data[7:0];
      end
      if (mem_we) tick_vld[mem_waddr] <= 1'b1;
      if (cmd.exit_free) begin
        used[run] <= 1'b0;
        count     <= count - CNT_W'(1);
      end
      if (cmd.spawn_step && spawn_hit) begin
        used[ptr] <= 1'b1;
        count     <= count + CNT_W'(1);
      end
      if (cmd.tick_wr) slice_cnt <= expired ? 8'd0 : slice_inc;
      if (cmd.pick_step) begin
        if (pick_hit) begin
          run       <= ptr;
          slice_cnt <= 8'd0;
        end else if (pick_last && exit_mode) begin
          run       <= '0;
          slice_cnt <= 8'd0;
        end
      end
      if (cmd.out_load)               out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.pick_start) begin
      ptr   <= run_plus;
      steps <= '0;
    end else if (cmd.spawn_start) begin
      ptr <= FIRST_SPAWN;
    end else if (cmd.pick_step || cmd.spawn_step) begin
      ptr   <= ptr_next;
      steps <= steps + IDX_W'(1);
    end

    if (cmd.load_item) begin
      func_r   <= in_data.func;
      idx_r    <= in_data.task_index;
      prev_r   <= run;
      sw_r     <= 1'b0;
      status_r <= STAT_DONE;
      newt_r   <= '0;
      rstate_r <= SLOT_FREE;
      rticks_r <= '0;
    end
    if (cmd.set_ignored) status_r <= STAT_IGNORED;
    if (cmd.pick_step && (pick_hit || (pick_last && exit_mode))) sw_r <= 1'b1;
    if (cmd.spawn_step) begin
      if (spawn_hit)       newt_r   <= ptr;
      else if (spawn_last) status_r <= STAT_NO_FREE;
    end
    if (cmd.read_cap && rd_in_range) begin
      rstate_r <= rstate_val;
      rticks_r <= tick_vld[rd_addr] ? rticks_wide[31:0] : 32'd0;
    end

    if (cmd.out_load) begin
      out_data.switched      <= sw_r;
      out_data.previous_task <= prev_wide[3:0];
      out_data.current_task  <= run_wide[3:0];
      out_data.status        <= status_r;
      out_data.new_task      <= newt_wide[3:0];
      out_data.task_count    <= count_wide[4:0];
      out_data.read_state    <= rstate_r;
      out_data.read_ticks    <= rticks_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/round_robin_task_scheduler.sv @@
// Round-robin time-slice task scheduler, top level.
// Requests that search walk the slots slot by slot, in round-robin order or as a
//   free-slot scan (one slot per cycle).
// Only one request is in flight: a new request is taken once the last one's result is loaded.
// Reset (rst, sync, active high): slot 0 running, others free, tick counts zero.
// Depends on rrts_pkg, rrts_ctrl, rrts_dp.
`default_nettype none

module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // register writes: 0 enable, 1 slice length
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire req_t                  in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rsp_t                       out_data
);

  // The controller walks each request through decode, tick memory
  // read-modify-write, slot search, spawn scan or read capture, and
  // finish. The datapath keeps the slot table as a used-bit vector plus
  // the running slot index; any used slot that is not running is ready.
  // Tick counts live in a memory with one read and one write port and
  // per-slot valid bits, so never-written slots read as zero. The result
  // register lets a new request be taken while the previous result still waits.
  cmd_t  cmd;
  stat_t stat;

  rrts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrts_dp #(
    .MAX_TASKS (MAX_TASKS),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule

`default_nettype wire
